/* src/ybmc_pkg.sv */
// Shared types and constants for the YUYV to BGR mirror converter.
// No dependencies; imported by every module in src.
package ybmc_pkg;

	localparam int LINE_PAIRS_MAX = 512;
	localparam int COL_W          = $clog2(LINE_PAIRS_MAX);
	localparam int ADDR_W         = COL_W + 1;
	localparam int STORE_DEPTH    = 2 * LINE_PAIRS_MAX;
	localparam int LEN_W          = 10;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = LEN_W;
	localparam int CH_W           = 8;
	localparam int WORD_W         = 4 * CH_W;
	localparam int ARITH_W        = 19;

	localparam int COEF_RV = 359;
	localparam int COEF_GU = 88;
	localparam int COEF_GV = 183;
	localparam int COEF_BU = 454;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REFLECT_ENABLE = 1'b0,
		REG_LINE_PAIRS     = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} bgr_pixel_t;

endpackage

/* src/ybmc_pixel_cvt.sv */
// One-pixel YUV to BGR conversion: fixed-point coefficients, floor shift, clamp.
// Depends on ybmc_pkg.
module ybmc_pixel_cvt
	import ybmc_pkg::*;
(
	input  logic [CH_W-1:0] y_luma,
	input  logic [CH_W-1:0] u_chroma,
	input  logic [CH_W-1:0] v_chroma,
	output bgr_pixel_t      pixel
);

	localparam logic signed [ARITH_W-1:0] K_RV = ARITH_W'(COEF_RV);
	localparam logic signed [ARITH_W-1:0] K_GU = ARITH_W'(COEF_GU);
	localparam logic signed [ARITH_W-1:0] K_GV = ARITH_W'(COEF_GV);
	localparam logic signed [ARITH_W-1:0] K_BU = ARITH_W'(COEF_BU);

	logic signed [CH_W-1:0]    du;
	logic signed [CH_W-1:0]    dv;
	logic signed [ARITH_W-1:0] du_x;
	logic signed [ARITH_W-1:0] dv_x;
	logic signed [ARITH_W-1:0] ys;
	logic signed [ARITH_W-1:0] sum_b;
	logic signed [ARITH_W-1:0] sum_g;
	logic signed [ARITH_W-1:0] sum_r;

	function automatic logic [CH_W-1:0] clamp_shr(input logic signed [ARITH_W-1:0] s);
		logic signed [ARITH_W-1:0] q;
		q = s >>> CH_W;
		if (q < 0) begin
			return '0;
		end else if (q > ARITH_W'(255)) begin
			return '1;
		end
		return q[CH_W-1:0];
	endfunction

	// offset-binary to two's complement: x - 128
	assign du   = {~u_chroma[CH_W-1], u_chroma[CH_W-2:0]};
	assign dv   = {~v_chroma[CH_W-1], v_chroma[CH_W-2:0]};
	assign du_x = ARITH_W'(du);
	assign dv_x = ARITH_W'(dv);
	assign ys   = $signed({{(ARITH_W-2*CH_W){1'b0}}, y_luma, {CH_W{1'b0}}});

	assign sum_b = ys + K_BU * du_x;
	assign sum_g = ys - K_GU * du_x - K_GV * dv_x;
	assign sum_r = ys + K_RV * dv_x;

	assign pixel.blue  = clamp_shr(sum_b);
	assign pixel.green = clamp_shr(sum_g);
	assign pixel.red   = clamp_shr(sum_r);

endmodule

/* src/yuyv_to_bgr_mirror_converter_unit.sv */
// Top level: YUYV 4:2:2 macropixel stream to BGR pixel pairs, optional line mirror.
// Depends on ybmc_pkg and ybmc_pixel_cvt; holds the ping-pong line store.
// Output path: the line store read is registered into stage 1, then converted into the output register.
// Throughput: one macropixel per cycle while m_tready does not stall the output.
// Reset clears control state and config (reflect off, 320 pairs); the line
// store is not cleared. In mirror mode the first line yields no output.
module yuyv_to_bgr_mirror_converter_unit
	import ybmc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [WORD_W-1:0]     s_tdata,   // y_first, u_chroma, y_second, v_chroma
	input  logic                  s_tuser,   // drain
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [6*CH_W-1:0]     m_tdata,   // blue_left, green_left, red_left,
	                                         // blue_right, green_right, red_right
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic              reflect_q;
	logic [LEN_W-1:0]  line_pairs_q;
	logic [COL_W-1:0]  col_q;
	logic              wbank_q;
	logic              prior_q;

	logic [WORD_W-1:0] line_store [STORE_DEPTH];

	logic              s_fire;
	logic              adv_out;
	logic [LEN_W-1:0]  len_c;
	logic [COL_W-1:0]  lenm1_c;
	logic              last_c;
	logic [COL_W-1:0]  rd_c;
	logic              ignore_c;
	logic              emit_c;

	logic              valid_s1;
	logic              mirror_s1;
	logic              last_s1;
	logic [WORD_W-1:0] pix_s1;
	logic [WORD_W-1:0] rdata_s1;

	logic [WORD_W-1:0] word_c;
	logic [CH_W-1:0]   yl_c;
	logic [CH_W-1:0]   yr_c;
	logic [CH_W-1:0]   u_c;
	logic [CH_W-1:0]   v_c;
	bgr_pixel_t        px_left;
	bgr_pixel_t        px_right;

	logic [6*CH_W-1:0] data_q;
	logic              last_q;
	logic              mvalid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reflect_q    <= 1'b0;
			line_pairs_q <= LEN_W'(320);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_REFLECT_ENABLE: reflect_q    <= cfg_data[0];
				REG_LINE_PAIRS:     line_pairs_q <= cfg_data[LEN_W-1:0];
				default:            ;
			endcase
		end
	end

	// line control
	always_comb begin
		if (line_pairs_q == '0) begin
			len_c = LEN_W'(1);
		end else if (line_pairs_q > LEN_W'(LINE_PAIRS_MAX)) begin
			len_c = LEN_W'(LINE_PAIRS_MAX);
		end else begin
			len_c = line_pairs_q;
		end
	end

	assign lenm1_c  = COL_W'(len_c - LEN_W'(1));
	assign last_c   = (col_q >= lenm1_c);
	assign rd_c     = last_c && (col_q != lenm1_c) ? '0 : COL_W'(lenm1_c - col_q);
	assign ignore_c = s_tuser && (!reflect_q || !prior_q);
	assign emit_c   = !ignore_c && (!reflect_q || prior_q);

	assign adv_out  = !mvalid_q || m_tready;
	assign s_tready = !valid_s1 || adv_out;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			wbank_q <= 1'b0;
			prior_q <= 1'b0;
		end else if (s_fire && !ignore_c) begin
			if (last_c) begin
				col_q   <= '0;
				wbank_q <= ~wbank_q;
				prior_q <= ~s_tuser;
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// ping-pong line store: write current bank, read the other
	always_ff @(posedge clk) begin
		if (s_fire && !s_tuser) begin
			line_store[{wbank_q, col_q}] <= s_tdata;
		end
		if (s_fire) begin
			rdata_s1 <= line_store[{~wbank_q, rd_c}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_fire && emit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			mirror_s1 <= reflect_q;
			last_s1   <= last_c;
			pix_s1    <= s_tdata;
		end
	end

	// mirrored read swaps the two lumas
	assign word_c = mirror_s1 ? rdata_s1 : pix_s1;
	assign u_c    = word_c[2*CH_W-1:CH_W];
	assign v_c    = word_c[4*CH_W-1:3*CH_W];
	assign yl_c   = mirror_s1 ? word_c[3*CH_W-1:2*CH_W] : word_c[CH_W-1:0];
	assign yr_c   = mirror_s1 ? word_c[CH_W-1:0] : word_c[3*CH_W-1:2*CH_W];

	ybmc_pixel_cvt u_cvt_left (
		.y_luma   (yl_c),
		.u_chroma (u_c),
		.v_chroma (v_c),
		.pixel    (px_left)
	);

	ybmc_pixel_cvt u_cvt_right (
		.y_luma   (yr_c),
		.u_chroma (u_c),
		.v_chroma (v_c),
		.pixel    (px_right)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (adv_out) begin
			mvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			data_q <= {px_right, px_left};
			last_q <= last_s1;
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

	a_emit_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && emit_c |=> valid_s1)
		else $error("accepted transaction with output did not reach stage 1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_out |=> valid_s1 && $stable(last_s1))
		else $error("stage 1 lost or changed while stalled");

	a_line_end_flips_bank: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && !ignore_c && last_c |=> wbank_q != $past(wbank_q) && col_q == '0)
		else $error("line end did not flip bank");

	a_drain_end_clears_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_tuser && !ignore_c && last_c |=> !prior_q)
		else $error("drained line left prior line marked ready");

	a_ignored_drain_no_state: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && ignore_c |=> $stable(col_q) && $stable(wbank_q) && $stable(prior_q))
		else $error("ignored drain changed line state");

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Testbench for yuyv_to_bgr_mirror_converter_unit: random and directed macropixel
// streams, direct and mirrored lines, checked against an in-bench BGR line predictor.
// Depends on ybmc_pkg and the RTL under src.
module testbench
	import ybmc_pkg::*;
();

	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 4000;
	localparam int SETTLE_TICKS = 4;
	localparam int ITEM_TARGET  = 1500;
	localparam int LOOP_TARGET  = ITEM_TARGET - 2 * LINE_PAIRS_MAX;

	typedef struct packed {
		logic [CH_W-1:0] v_chroma;
		logic [CH_W-1:0] y_second;
		logic [CH_W-1:0] u_chroma;
		logic [CH_W-1:0] y_first;
	} yuyv_word_t;

	typedef struct packed {
		logic       drain;
		yuyv_word_t px;
	} yuyv_item_t;

	typedef struct packed {
		logic       line_last;
		bgr_pixel_t right;
		bgr_pixel_t left;
	} bgr_pair_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [WORD_W-1:0]     s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [6*CH_W-1:0]     m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_REFLECT_ENABLE;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	yuyv_item_t yuyv_pending[$];
	bgr_pair_t  bgr_due[$];
	int         items_queued  = 0;
	int         items_taken   = 0;
	int         mismatches    = 0;
	int         send_idle_pct = 11;
	int         recv_idle_pct = 47;
	int         quiet_cycles  = 0;
	int         hold_left     = 0;
	bit         hold_req      = 1'b0;
	bit         hold_done     = 1'b0;

	// predictor state
	logic [WORD_W-1:0]     line_mem [STORE_DEPTH];
	int unsigned           wr_col       = 0;
	int unsigned           wr_bank      = 0;
	bit                    prev_line_ok = 1'b0;
	bit                    mirror_on    = 1'b0;
	logic [CFG_DATA_W-1:0] pairs_cfg    = 10'd320;

	// stimulus planning
	bit          plan_ready = 1'b0;
	int unsigned plan_len   = 1;
	int          counted    = 0;

	string chan_name [6] = '{"blue_left", "green_left", "red_left",
		"blue_right", "green_right", "red_right"};

	yuyv_to_bgr_mirror_converter_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic logic [CH_W-1:0] clamp_chan(int acc);
		int q;
		q = acc >>> 8;
		if (q < 0)
			return 8'd0;
		if (q > 255)
			return 8'd255;
		return q[CH_W-1:0];
	endfunction

	function automatic bgr_pixel_t yuv_pixel(logic [CH_W-1:0] y, int du, int dv);
		bgr_pixel_t p;
		int         ys;
		ys      = int'(y) * 256;
		p.blue  = clamp_chan(ys + COEF_BU * du);
		p.green = clamp_chan(ys - COEF_GU * du - COEF_GV * dv);
		p.red   = clamp_chan(ys + COEF_RV * dv);
		return p;
	endfunction

	// one accepted macropixel: store write, optional mirrored read, line bookkeeping
	function automatic void mirror_convert_step(yuyv_word_t px, logic drain);
		int unsigned eff, col, rd;
		logic        at_end;
		yuyv_word_t  src;
		bgr_pair_t   res;
		int          du, dv;
		eff = (pairs_cfg == 0) ? 1 :
			(pairs_cfg > LINE_PAIRS_MAX) ? LINE_PAIRS_MAX : pairs_cfg;
		if (drain && (!mirror_on || !prev_line_ok))
			return;
		col    = (wr_col >= LINE_PAIRS_MAX) ? LINE_PAIRS_MAX - 1 : wr_col;
		at_end = (col >= eff - 1);
		if (!mirror_on || prev_line_ok) begin
			rd  = (col < eff) ? eff - 1 - col : 0;
			src = mirror_on ? line_mem[(wr_bank ^ 1) * LINE_PAIRS_MAX + rd] : px;
			du  = int'(src.u_chroma) - 128;
			dv  = int'(src.v_chroma) - 128;
			res.left      = yuv_pixel(mirror_on ? src.y_second : src.y_first, du, dv);
			res.right     = yuv_pixel(mirror_on ? src.y_first : src.y_second, du, dv);
			res.line_last = at_end;
			bgr_due.push_back(res);
		end
		if (!drain)
			line_mem[wr_bank * LINE_PAIRS_MAX + col] = px;
		if (at_end) begin
			wr_col       = 0;
			wr_bank      = wr_bank ^ 1;
			prev_line_ok = !drain;
		end else begin
			wr_col = col + 1;
		end
	endfunction

	// input driver
	always @(posedge clk) begin : drive_in
		yuyv_item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				mirror_convert_step(s_tdata, s_tuser);
				items_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (yuyv_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = yuyv_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.px;
					s_tuser  <= nxt.drain;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output monitor and receiver backpressure
	always @(posedge clk) begin : watch_out
		bgr_pair_t         exp_res;
		logic [6*CH_W-1:0] exp_px;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (bgr_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: data %h last %b", m_tdata, m_tlast);
				end else begin
					exp_res = bgr_due.pop_front();
					exp_px  = {exp_res.right, exp_res.left};
					for (int ch = 0; ch < 6; ch++)
						if (m_tdata[ch*CH_W +: CH_W] !== exp_px[ch*CH_W +: CH_W]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("%s: expected %0d, got %0d", chan_name[ch],
									exp_px[ch*CH_W +: CH_W], m_tdata[ch*CH_W +: CH_W]);
						end
					if (m_tlast !== exp_res.line_last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("line_last: expected %b, got %b",
								exp_res.line_last, m_tlast);
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("yuyv_to_bgr_mirror_converter_unit: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic wait_quiet();
		do
			@(posedge clk);
		while (items_taken != items_queued || bgr_due.size() != 0);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic set_mode(bit mirror, logic [CFG_DATA_W-1:0] lp);
		cfg_reg_t              idx;
		logic [CFG_DATA_W-1:0] val;
		wait_quiet();
		for (int r = 0; r < 2; r++) begin
			idx = (r == 0) ? REG_REFLECT_ENABLE : REG_LINE_PAIRS;
			val = (r == 0) ? CFG_DATA_W'(mirror) : lp;
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= val;
			do
				@(posedge clk);
			while (!cfg_ready);
			if (idx == REG_REFLECT_ENABLE)
				mirror_on = val[0];
			else
				pairs_cfg = val;
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_item(yuyv_word_t px, logic drain);
		yuyv_pending.push_back('{drain: drain, px: px});
		items_queued++;
	endtask

	// whole lines only, so every mirrored read hits an entry written by the stored line
	task automatic run_lines(bit mirror, logic [CFG_DATA_W-1:0] lp, int lines, bit flush);
		int unsigned eff;
		bit          rdy;
		eff = (lp == 0) ? 1 : (lp > LINE_PAIRS_MAX) ? LINE_PAIRS_MAX : lp;
		rdy = plan_ready;
		set_mode(mirror, lp);
		for (int ln = 0; ln < lines; ln++) begin
			for (int c = 0; c < eff; c++) begin
				if ((!mirror || !rdy) && $urandom_range(9) == 0)
					queue_item($urandom, 1'b1);
				queue_item($urandom, 1'b0);
			end
			rdy = 1'b1;
		end
		counted += lines * eff;
		if (mirror && flush && rdy) begin
			for (int c = 0; c < eff; c++)
				queue_item($urandom, 1'b1);
			counted += eff;
			rdy = 1'b0;
		end
		if (lines > 0)
			plan_len = eff;
		plan_ready = rdy;
	endtask

	initial begin : stimulus
		bit                    mirror;
		logic [CFG_DATA_W-1:0] lp;
		int                    pick;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// direct mode, color extremes; drain is ignored (fields: v, y2, u, y1)
		set_mode(1'b0, 10'd4);
		queue_item({8'd0, 8'd255, 8'd0, 8'd0}, 1'b0);
		queue_item({8'd77, 8'd3, 8'd200, 8'd9}, 1'b1);
		queue_item({8'd255, 8'd0, 8'd255, 8'd255}, 1'b0);
		queue_item({8'd128, 8'd128, 8'd128, 8'd128}, 1'b0);
		queue_item({8'd255, 8'd235, 8'd0, 8'd16}, 1'b0);

		// line length shortened mid-line: next item closes the line
		set_mode(1'b0, 10'd8);
		for (int c = 0; c < 5; c++)
			queue_item($urandom, 1'b0);
		set_mode(1'b0, 10'd3);
		queue_item($urandom, 1'b0);

		// mirror of the stored direct line, then shortened mid-line: read index saturates
		set_mode(1'b1, 10'd4);
		for (int c = 0; c < 7; c++)
			queue_item($urandom, 1'b0);
		set_mode(1'b1, 10'd2);
		queue_item($urandom, 1'b0);

		// zero length acts as one; flush, drain with nothing stored, first line silent
		set_mode(1'b1, 10'd0);
		queue_item($urandom, 1'b1);
		queue_item($urandom, 1'b1);
		queue_item($urandom, 1'b0);
		queue_item($urandom, 1'b0);
		queue_item($urandom, 1'b1);
		plan_ready = 1'b0;
		plan_len   = 1;

		// long receiver hold while the sender keeps offering
		run_lines(1'b0, 10'd16, 8, 1'b0);
		hold_req = 1'b1;

		while (counted < LOOP_TARGET) begin
			if (counted < LOOP_TARGET / 2) begin
				send_idle_pct = 11;
				recv_idle_pct = 47;
			end else begin
				send_idle_pct = 47;
				recv_idle_pct = 11;
			end
			pick   = int'($urandom_range(19));
			mirror = 1'($urandom_range(1));
			if (pick == 0)
				lp = 10'd0;
			else if (pick < 3)
				lp = CFG_DATA_W'($urandom_range(64, 24));
			else
				lp = CFG_DATA_W'($urandom_range(12, 1));
			if (mirror && plan_ready && (lp == 0 ? 1 : lp) > plan_len)
				lp = CFG_DATA_W'($urandom_range(plan_len, 1));
			run_lines(mirror, lp, int'($urandom_range(4, 1)), 1'($urandom_range(1)));
		end

		send_idle_pct = 0;
		recv_idle_pct = 0;

		// out-of-range length clamps to LINE_PAIRS_MAX, then a full-size mirrored flush
		run_lines(1'b0, 10'd1023, 1, 1'b0);
		run_lines(1'b1, 10'd512, 0, 1'b1);

		wait_quiet();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && bgr_due.size() == 0)
			$display("yuyv_to_bgr_mirror_converter_unit: match");
		else
			$display("yuyv_to_bgr_mirror_converter_unit: mismatch");
		$finish;
	end

endmodule
